[hdl/pzc_pkg.sv]
// shared types and constants for the pid controller with zero-cross integral clear
// no dependencies
`timescale 1ns / 1ps

package pzc_pkg;

  // gain format and register widths
  localparam int GAIN_WIDTH      = 16;
  localparam int LIMIT_WIDTH     = 15;
  localparam int CFG_DATA_WIDTH  = 16;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int DRIVE_WIDTH     = 32;

  // reset value of the windup limit
  localparam logic [LIMIT_WIDTH-1:0] DEFAULT_WINDUP = LIMIT_WIDTH'(15);

  // configuration register indexes
  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_GAIN_P  = 2'd0,
    REG_GAIN_I  = 2'd1,
    REG_GAIN_D  = 2'd2,
    REG_WINDUP  = 2'd3
  } cfg_reg_t;

  // the three loop gains, signed fixed point
  typedef struct packed {
    logic signed [GAIN_WIDTH-1:0] kp;
    logic signed [GAIN_WIDTH-1:0] ki;
    logic signed [GAIN_WIDTH-1:0] kd;
  } gains_t;

endpackage

[hdl/pzc_front.sv]
// front stage: zero-cross clear, integral and last-error update, operand register
// depends on pzc_pkg
`timescale 1ns / 1ps

module pzc_front import pzc_pkg::*; #(
  parameter int ERROR_WIDTH    = 16,
  parameter int INTEGRAL_WIDTH = 24
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [ERROR_WIDTH-1:0]    error_sample,
  input  logic [LIMIT_WIDTH-1:0]           windup_limit,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [ERROR_WIDTH-1:0]    op_error,
  output logic signed [ERROR_WIDTH:0]      op_deriv,
  output logic signed [INTEGRAL_WIDTH-1:0] op_integ
);

  localparam int EW = ERROR_WIDTH;
  localparam int IW = INTEGRAL_WIDTH;
  localparam int DW = EW + 1;
  localparam int AW = ((IW > EW) ? IW : EW) + 1;
  localparam int MW = (EW > LIMIT_WIDTH) ? EW : LIMIT_WIDTH;
  localparam logic signed [IW-1:0] IMAX = {1'b0, {(IW-1){1'b1}}};
  localparam logic signed [IW-1:0] IMIN = {1'b1, {(IW-1){1'b0}}};

  logic signed [EW-1:0] last_error;
  logic signed [IW-1:0] error_sum;
  logic signed [IW-1:0] error_sum_next;
  logic signed [IW-1:0] integ_used;
  logic signed [DW-1:0] deriv;
  logic signed [AW-1:0] integ_wide;
  logic [EW-1:0]        mag;
  logic                 sign_flip;
  logic                 accumulate;
  logic                 accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // integral is cleared when the sign strictly flips
  assign sign_flip = ((last_error > 0) && (error_sample < 0)) ||
                     ((last_error < 0) && (error_sample > 0));
  assign integ_used = sign_flip ? '0 : error_sum;

  assign deriv = DW'(error_sample) - DW'(last_error);

  // magnitude, most negative value reads as 2^(EW-1) unsigned
  assign mag = error_sample[EW-1] ? EW'(~error_sample + 1'b1) : EW'(error_sample);
  assign accumulate = MW'(mag) < MW'(windup_limit);

  // saturating integral update
  always_comb begin
    integ_wide     = AW'(integ_used) + AW'(error_sample);
    error_sum_next = integ_used;
    if (accumulate) begin
      if (integ_wide > AW'(IMAX)) begin
        error_sum_next = IMAX;
      end else if (integ_wide < AW'(IMIN)) begin
        error_sum_next = IMIN;
      end else begin
        error_sum_next = integ_wide[IW-1:0];
      end
    end
  end

  // loop state and valid
  always_ff @(posedge clk) begin
    if (rst) begin
      last_error <= '0;
      error_sum  <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (accept) begin
        last_error <= error_sample;
        error_sum  <= error_sum_next;
      end
      if (in_ready) begin
        out_valid <= in_valid;
      end
    end
  end

  // operand register
  always_ff @(posedge clk) begin
    if (accept) begin
      op_error <= error_sample;
      op_deriv <= deriv;
      op_integ <= integ_used;
    end
  end

endmodule

[hdl/pzc_mult.sv]
// multiply stage: the three gain products, registered
// depends on pzc_pkg
`timescale 1ns / 1ps

module pzc_mult import pzc_pkg::*; #(
  parameter int ERROR_WIDTH    = 16,
  parameter int INTEGRAL_WIDTH = 24
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        in_valid,
  output logic                                        in_ready,
  input  logic signed [ERROR_WIDTH-1:0]               op_error,
  input  logic signed [ERROR_WIDTH:0]                 op_deriv,
  input  logic signed [INTEGRAL_WIDTH-1:0]            op_integ,
  input  gains_t                                      gains,
  output logic                                        out_valid,
  input  logic                                        out_ready,
  output logic signed [ERROR_WIDTH+GAIN_WIDTH-1:0]    prod_p,
  output logic signed [INTEGRAL_WIDTH+GAIN_WIDTH-1:0] prod_i,
  output logic signed [ERROR_WIDTH+GAIN_WIDTH:0]      prod_d
);

  localparam int PW = ERROR_WIDTH + GAIN_WIDTH;
  localparam int QW = INTEGRAL_WIDTH + GAIN_WIDTH;
  localparam int RW = ERROR_WIDTH + GAIN_WIDTH + 1;

  logic signed [PW-1:0] prod_p_next;
  logic signed [QW-1:0] prod_i_next;
  logic signed [RW-1:0] prod_d_next;
  logic                 accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // signed products at full width
  assign prod_p_next = PW'(op_error) * PW'(gains.kp);
  assign prod_i_next = QW'(op_integ) * QW'(gains.ki);
  assign prod_d_next = RW'(op_deriv) * RW'(gains.kd);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prod_p <= prod_p_next;
      prod_i <= prod_i_next;
      prod_d <= prod_d_next;
    end
  end

endmodule

[hdl/pzc_sum.sv]
// sum stage: add products, drop fraction bits, saturate, output register
// depends on pzc_pkg
`timescale 1ns / 1ps

module pzc_sum import pzc_pkg::*; #(
  parameter int ERROR_WIDTH    = 16,
  parameter int INTEGRAL_WIDTH = 24,
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        in_valid,
  output logic                                        in_ready,
  input  logic signed [ERROR_WIDTH+GAIN_WIDTH-1:0]    prod_p,
  input  logic signed [INTEGRAL_WIDTH+GAIN_WIDTH-1:0] prod_i,
  input  logic signed [ERROR_WIDTH+GAIN_WIDTH:0]      prod_d,
  output logic                                        out_valid,
  input  logic                                        out_ready,
  output logic signed [DRIVE_WIDTH-1:0]               drive_value
);

  localparam int BW = ((INTEGRAL_WIDTH > ERROR_WIDTH + 1) ?
                       INTEGRAL_WIDTH : ERROR_WIDTH + 1) + GAIN_WIDTH + 2;
  localparam int WW = (BW > DRIVE_WIDTH + 1) ? BW : DRIVE_WIDTH + 1;
  localparam logic signed [DRIVE_WIDTH-1:0] DMAX = {1'b0, {(DRIVE_WIDTH-1){1'b1}}};
  localparam logic signed [DRIVE_WIDTH-1:0] DMIN = {1'b1, {(DRIVE_WIDTH-1){1'b0}}};

  logic signed [WW-1:0]          total;
  logic signed [WW-1:0]          shifted;
  logic signed [DRIVE_WIDTH-1:0] drive_next;
  logic                          accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // sum, floor shift and clamp to the drive range
  always_comb begin
    total   = WW'(prod_p) + WW'(prod_i) + WW'(prod_d);
    shifted = total >>> GAIN_FRAC_BITS;
    if (shifted > WW'(DMAX)) begin
      drive_next = DMAX;
    end else if (shifted < WW'(DMIN)) begin
      drive_next = DMIN;
    end else begin
      drive_next = shifted[DRIVE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      drive_value <= drive_next;
    end
  end

endmodule

[hdl/pid_zero_cross_reset.sv]
// pid_zero_cross_reset: pid step with integral clear when the error changes sign
// path: input beat to output beat through the operand, product and sum registers
// throughput: one beat per cycle while out_ready holds; the integral and last-error
//   update is one front-stage add and clamp, so back-to-back beats see the new state
// reset: gains 0, windup limit 15, last error and integral 0, pipeline empty
// depends on pzc_pkg, pzc_front, pzc_mult, pzc_sum
`timescale 1ns / 1ps

module pid_zero_cross_reset import pzc_pkg::*; #(
  parameter int ERROR_WIDTH    = 16,
  parameter int INTEGRAL_WIDTH = 24,
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [CFG_INDEX_WIDTH-1:0]    cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [ERROR_WIDTH-1:0] error_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [DRIVE_WIDTH-1:0] drive_value
);

  gains_t                                      gains;
  logic [LIMIT_WIDTH-1:0]                      windup_limit;
  logic                                        op_valid;
  logic                                        op_ready;
  logic signed [ERROR_WIDTH-1:0]               op_error;
  logic signed [ERROR_WIDTH:0]                 op_deriv;
  logic signed [INTEGRAL_WIDTH-1:0]            op_integ;
  logic                                        prod_valid;
  logic                                        prod_ready;
  logic signed [ERROR_WIDTH+GAIN_WIDTH-1:0]    prod_p;
  logic signed [INTEGRAL_WIDTH+GAIN_WIDTH-1:0] prod_i;
  logic signed [ERROR_WIDTH+GAIN_WIDTH:0]      prod_d;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gains        <= '0;
      windup_limit <= DEFAULT_WINDUP;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_GAIN_P: gains.kp     <= cfg_data[GAIN_WIDTH-1:0];
        REG_GAIN_I: gains.ki     <= cfg_data[GAIN_WIDTH-1:0];
        REG_GAIN_D: gains.kd     <= cfg_data[GAIN_WIDTH-1:0];
        REG_WINDUP: windup_limit <= cfg_data[LIMIT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // loop state and operands
  pzc_front #(
    .ERROR_WIDTH   (ERROR_WIDTH),
    .INTEGRAL_WIDTH(INTEGRAL_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .error_sample(error_sample),
    .windup_limit(windup_limit),
    .out_valid   (op_valid),
    .out_ready   (op_ready),
    .op_error    (op_error),
    .op_deriv    (op_deriv),
    .op_integ    (op_integ)
  );

  // gain products
  pzc_mult #(
    .ERROR_WIDTH   (ERROR_WIDTH),
    .INTEGRAL_WIDTH(INTEGRAL_WIDTH)
  ) u_mult (
    .clk      (clk),
    .rst      (rst),
    .in_valid (op_valid),
    .in_ready (op_ready),
    .op_error (op_error),
    .op_deriv (op_deriv),
    .op_integ (op_integ),
    .gains    (gains),
    .out_valid(prod_valid),
    .out_ready(prod_ready),
    .prod_p   (prod_p),
    .prod_i   (prod_i),
    .prod_d   (prod_d)
  );

  // sum and saturate
  pzc_sum #(
    .ERROR_WIDTH   (ERROR_WIDTH),
    .INTEGRAL_WIDTH(INTEGRAL_WIDTH),
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) u_sum (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (prod_valid),
    .in_ready   (prod_ready),
    .prod_p     (prod_p),
    .prod_i     (prod_i),
    .prod_d     (prod_d),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .drive_value(drive_value)
  );

endmodule

[tb/sv/pzc_drive_checker.sv]
// checker for pid_zero_cross_reset: tracks register writes, predicts each drive value
// from the accepted error beats and compares it with the output beats; depends on pzc_pkg
`timescale 1ns / 1ps

module pzc_drive_checker import pzc_pkg::*; #(
  parameter int ERROR_WIDTH    = 16,
  parameter int INTEGRAL_WIDTH = 24,
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [CFG_INDEX_WIDTH-1:0]    cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]     cfg_data,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic signed [ERROR_WIDTH-1:0] error_sample,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic signed [DRIVE_WIDTH-1:0] drive_value,
  output int                            fail_count,
  output int                            pending
);

  localparam longint INTEG_MAX = (longint'(1) <<< (INTEGRAL_WIDTH - 1)) - 1;
  localparam longint INTEG_MIN = -INTEG_MAX - 1;
  localparam longint DRIVE_MAX = (longint'(1) <<< (DRIVE_WIDTH - 1)) - 1;
  localparam longint DRIVE_MIN = -DRIVE_MAX - 1;

  // shadow copy of the registers and the loop state
  logic signed [GAIN_WIDTH-1:0]     kp, ki, kd;
  logic [LIMIT_WIDTH-1:0]           windup;
  logic signed [ERROR_WIDTH-1:0]    prev_err;
  logic signed [INTEGRAL_WIDTH-1:0] integral;

  // drive values still owed by the block, oldest first
  logic signed [DRIVE_WIDTH-1:0] drive_expected [$];

  // one controller step: returns the drive value and advances prev_err and integral
  function automatic logic signed [DRIVE_WIDTH-1:0] pid_drive_next(
    input logic signed [ERROR_WIDTH-1:0] e
  );
    longint ev;
    longint dv;
    longint iv;
    longint acc;
    longint mag;
    ev = e;
    dv = ev - longint'(prev_err);
    iv = integral;
    // sign change strictly across zero clears the integral before use
    if ((prev_err > 0 && e < 0) || (prev_err < 0 && e > 0)) begin
      iv = 0;
    end
    acc = ev * longint'(kp) + iv * longint'(ki) + dv * longint'(kd);
    acc = acc >>> GAIN_FRAC_BITS;
    if (acc > DRIVE_MAX) begin
      acc = DRIVE_MAX;
    end
    if (acc < DRIVE_MIN) begin
      acc = DRIVE_MIN;
    end
    // accumulate only below the windup limit, clamped to the integral width
    mag = (ev < 0) ? -ev : ev;
    if (mag < longint'(windup)) begin
      iv = iv + ev;
      if (iv > INTEG_MAX) begin
        iv = INTEG_MAX;
      end
      if (iv < INTEG_MIN) begin
        iv = INTEG_MIN;
      end
    end
    integral = iv[INTEGRAL_WIDTH-1:0];
    prev_err = e;
    return acc[DRIVE_WIDTH-1:0];
  endfunction

  // register writes, input beats and output beats, all sampled at the rising edge
  always @(posedge clk) begin : track
    logic signed [DRIVE_WIDTH-1:0] want;
    if (rst) begin
      kp = '0;
      ki = '0;
      kd = '0;
      windup = DEFAULT_WINDUP;
      prev_err = '0;
      integral = '0;
      drive_expected.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (cfg_write) begin
        case (cfg_reg_t'(cfg_index))
          REG_GAIN_P: kp = cfg_data[GAIN_WIDTH-1:0];
          REG_GAIN_I: ki = cfg_data[GAIN_WIDTH-1:0];
          REG_GAIN_D: kd = cfg_data[GAIN_WIDTH-1:0];
          REG_WINDUP: windup = cfg_data[LIMIT_WIDTH-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        drive_expected.push_back(pid_drive_next(error_sample));
      end
      if (out_valid && out_ready) begin
        if (drive_expected.size() == 0) begin
          $error("drive_value beat with nothing predicted: expected none, actual %0d",
                 drive_value);
          fail_count <= fail_count + 1;
        end else begin
          want = drive_expected.pop_front();
          if (drive_value !== want) begin
            $error("drive_value mismatch: expected %0d, actual %0d", want, drive_value);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= drive_expected.size();
    end
  end

endmodule

[tb/sv/pid_zero_cross_reset_tb.sv]
// testbench top for pid_zero_cross_reset: clock, reset, register writes, error beats,
// output back-pressure and the verdict; depends on pzc_pkg and pzc_drive_checker
`timescale 1ns / 1ps

module pid_zero_cross_reset_tb;
  import pzc_pkg::*;

  localparam int ERR_W       = 16;
  localparam int STALL_LIMIT = 4000;

  typedef enum int {
    SEG_NOISE,
    SEG_RUN,
    SEG_CROSS,
    SEG_CORNER,
    SEG_WINDUP
  } seg_kind_t;

  localparam logic signed [ERR_W-1:0] CORNER_ERRORS [0:19] = '{
    32767, -32768, 32767, 0, -32768, 0, 32767, -1, 1, 32766,
    32766, -32767, -32766, 0, 0, 5, -5, 1, 1, -32768
  };

  logic                          clk;
  logic                          rst;
  logic                          cfg_write;
  logic [CFG_INDEX_WIDTH-1:0]    cfg_index;
  logic [CFG_DATA_WIDTH-1:0]     cfg_data;
  logic                          in_valid;
  logic                          in_ready;
  logic signed [ERR_W-1:0]       error_sample;
  logic                          out_valid;
  logic                          out_ready;
  logic signed [DRIVE_WIDTH-1:0] drive_value;

  int fail_count;
  int pending;
  int send_idle_pct = 37;
  int recv_idle_pct = 71;
  int active_limit  = 15;
  int stall_cycles;

  pid_zero_cross_reset dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .error_sample (error_sample),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .drive_value  (drive_value)
  );

  pzc_drive_checker drive_monitor (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .error_sample (error_sample),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .drive_value  (drive_value),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // output back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // one error beat, with random idle cycles ahead of it
  task automatic send_error(input logic signed [ERR_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    error_sample <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // stop sending and wait until every predicted drive value has come out
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_WIDTH-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic load_gains(input logic [CFG_DATA_WIDTH-1:0] p, i, d, w);
    write_reg(REG_GAIN_P, p);
    write_reg(REG_GAIN_I, i);
    write_reg(REG_GAIN_D, d);
    write_reg(REG_WINDUP, w);
    cfg_write <= 1'b0;
    active_limit = int'(w[LIMIT_WIDTH-1:0]);
  endtask

  // random error value of a given segment kind; lim is the current windup limit
  function automatic logic signed [ERR_W-1:0] pick_error(
    input seg_kind_t kind, input bit neg, input int lim
  );
    int cap;
    int mag;
    cap = (lim + 2 > 32767) ? 32767 : lim + 2;
    case (kind)
      SEG_NOISE: return ERR_W'($urandom());
      SEG_RUN: begin
        mag = $urandom_range(cap, 0);
        return ERR_W'(neg ? -mag : mag);
      end
      SEG_CROSS: begin
        mag = $urandom_range(1) ? $urandom_range(cap, 1) : $urandom_range(32767, 1);
        return ERR_W'(neg ? -mag : mag);
      end
      SEG_CORNER: begin
        case ($urandom_range(7))
          0: return 32767;
          1: return -32768;
          2: return 0;
          3: return 1;
          4: return -1;
          5: return ERR_W'(lim);
          6: return ERR_W'(-lim);
          default: return ERR_W'(lim - 1);
        endcase
      end
      default: begin
        mag = $urandom_range(32766, 28000);
        return ERR_W'(neg ? -mag : mag);
      end
    endcase
  endfunction

  // random segments: noise, same-sign runs, sign flips and corner values
  task automatic send_random(input int count);
    seg_kind_t kind;
    int left;
    bit neg;
    left = 0;
    kind = SEG_NOISE;
    neg = 1'b0;
    for (int n = 0; n < count; n++) begin
      if (left == 0) begin
        kind = seg_kind_t'($urandom_range(3));
        left = (kind == SEG_NOISE) ? $urandom_range(12, 1) : $urandom_range(40, 3);
        neg = 1'($urandom_range(1));
      end
      if (kind == SEG_CROSS) begin
        neg = !neg;
      end
      send_error(pick_error(kind, neg, active_limit));
      left--;
    end
  endtask

  // long same-sign run of large errors to drive the integral into its clamp
  task automatic send_burst(input int count, input bit neg);
    for (int n = 0; n < count; n++) begin
      send_error(pick_error(SEG_WINDUP, neg, active_limit));
    end
  endtask

  initial begin
    rst          <= 1'b1;
    cfg_write    <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    in_valid     <= 1'b0;
    error_sample <= '0;
    out_ready    <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset values of the registers, with a sign change and a zero
    send_error(5);
    send_error(-3);
    send_error(0);
    drain_pipeline();

    // extreme gains, widest windup limit: corner errors
    load_gains(16'h7fff, 16'h8000, 16'h7fff, 16'h7fff);
    foreach (CORNER_ERRORS[k]) begin
      send_error(CORNER_ERRORS[k]);
    end
    drain_pipeline();

    // opposite extremes, windup limit zero with the unused data bit set
    load_gains(16'h8000, 16'h7fff, 16'h8000, 16'h8000);
    send_error(100);
    send_error(200);
    send_error(-32768);
    send_error(-200);
    drain_pipeline();

    // sender idles often, receiver more often; small windup limits
    repeat (2) begin
      load_gains(16'($urandom()), 16'($urandom()), 16'($urandom()),
                 {1'($urandom_range(1)), 15'($urandom_range(64))});
      send_random(200);
      drain_pipeline();
    end

    // roles swapped; windup limit anywhere
    send_idle_pct = 71;
    recv_idle_pct = 37;
    repeat (2) begin
      load_gains(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()));
      send_random(200);
      drain_pipeline();
    end

    // no idling: integral clamp both ways, then the smallest nonzero limit
    send_idle_pct = 0;
    recv_idle_pct = 0;
    load_gains(16'($urandom()), 16'($urandom()), 16'($urandom()),
               {1'($urandom_range(1)), 15'h7fff});
    send_burst(300, 1'b0);
    send_burst(300, 1'b1);
    send_random(150);
    drain_pipeline();
    load_gains(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'h0001);
    send_random(100);
    drain_pipeline();

    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
